// ===== design/grouped_departure_order_list_unit_assert.svh =====
// assertion macros for the grouped departure order list unit
// expects clk and rst_n in the scope of the including module
`ifndef GROUPED_DEPARTURE_ORDER_LIST_UNIT_ASSERT_SVH
`define GROUPED_DEPARTURE_ORDER_LIST_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define GDOL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("gdol invariant violated");

// condition in one cycle implies a result in the next
`define GDOL_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gdol sequence violated");

`endif

// ===== design/gdol_pkg.sv =====
// shared types, sizes and helpers of the grouped departure order list unit
// no dependencies
`default_nettype none

package gdol_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 16;
    localparam int GROUP_BITS = 3;
    localparam int POS_BITS   = 8;
    localparam int RANK_BITS  = 8;
    localparam int IDX_BITS   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int CMP_BITS   = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;
    localparam int SEG_SIZE   = (CAPACITY > 64) ? 16 : 8;
    localparam int NUM_SEG    = (CAPACITY + SEG_SIZE - 1) / SEG_SIZE;
    localparam int PAD_CELLS  = NUM_SEG * SEG_SIZE;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_EDIT  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,
        OP_FROM_LEFT  = 3'd1,
        OP_FROM_RIGHT = 3'd2,
        OP_LOAD       = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_SET_ACT    = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     act_val;
    } cell_ctl_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [GROUP_BITS-1:0] grp;
        logic                  active;
        logic                  used;
    } entry_t;

    typedef struct packed {
        logic cnt_en;
        logic pfx_en;
        logic sel_en;
    } rank_ctl_t;

    function automatic logic [IDX_BITS-1:0] onehot_to_idx(input logic [CAPACITY-1:0] v);
        logic [IDX_BITS-1:0] idx;
        idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (v[i])
            begin
                idx = idx | IDX_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== design/gdol_cell.sv =====
// one storage cell of the order row: key, group, active and used marks
// depends on gdol_pkg
`default_nettype none

module gdol_cell (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire gdol_pkg::cell_ctl_t                 ctl,
    input  wire gdol_pkg::entry_t                    left_in,
    input  wire gdol_pkg::entry_t                    right_in,
    input  wire logic [gdol_pkg::KEY_BITS-1:0]       load_key,
    input  wire logic [gdol_pkg::GROUP_BITS-1:0]     load_grp,
    input  wire logic [gdol_pkg::KEY_BITS-1:0]       probe_key,
    input  wire logic [gdol_pkg::GROUP_BITS-1:0]     probe_grp,
    output gdol_pkg::entry_t                         cur,
    output logic                                     hit,
    output logic                                     in_grp
);

    logic [gdol_pkg::KEY_BITS-1:0]   key_reg, key_next;
    logic [gdol_pkg::GROUP_BITS-1:0] grp_reg, grp_next;
    logic                            active_reg, active_next;
    logic                            used_reg, used_next;

    always_comb
    begin
        key_next    = key_reg;
        grp_next    = grp_reg;
        active_next = active_reg;
        used_next   = used_reg;
        case (ctl.op)
            gdol_pkg::OP_FROM_LEFT:
            begin
                key_next    = left_in.key;
                grp_next    = left_in.grp;
                active_next = left_in.active;
                used_next   = left_in.used;
            end
            gdol_pkg::OP_FROM_RIGHT:
            begin
                key_next    = right_in.key;
                grp_next    = right_in.grp;
                active_next = right_in.active;
                used_next   = right_in.used;
            end
            gdol_pkg::OP_LOAD:
            begin
                key_next    = load_key;
                grp_next    = load_grp;
                active_next = 1'b1;
                used_next   = 1'b1;
            end
            gdol_pkg::OP_CLEAR:
            begin
                active_next = 1'b0;
                used_next   = 1'b0;
            end
            gdol_pkg::OP_SET_ACT:
            begin
                active_next = ctl.act_val;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        grp_reg <= grp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            used_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            used_reg   <= used_next;
        end
    end

    assign cur    = '{key: key_reg, grp: grp_reg, active: active_reg, used: used_reg};
    assign hit    = used_reg && (key_reg == probe_key);
    assign in_grp = used_reg && active_reg && (grp_reg == probe_grp);

endmodule

`default_nettype wire

// ===== design/gdol_rank.sv =====
// segmented active prefix count over the cell row, rank pick and move target
// depends on gdol_pkg
`default_nettype none

module gdol_rank (
    input  wire logic                                 clk,
    input  wire gdol_pkg::rank_ctl_t                  ctl,
    input  wire logic [gdol_pkg::CAPACITY-1:0]        mask,
    input  wire logic [gdol_pkg::CAPACITY-1:0]        hit,
    input  wire logic [gdol_pkg::POS_BITS-1:0]        pos,
    output logic [gdol_pkg::CNT_BITS-1:0]             rank_val,
    output logic                                      tgt_found,
    output logic [gdol_pkg::IDX_BITS-1:0]             tgt_idx
);

    localparam int CAP  = gdol_pkg::CAPACITY;
    localparam int PAD  = gdol_pkg::PAD_CELLS;
    localparam int SEG  = gdol_pkg::SEG_SIZE;
    localparam int NSEG = gdol_pkg::NUM_SEG;
    localparam int CNTW = gdol_pkg::CNT_BITS;
    localparam int CMPW = gdol_pkg::CMP_BITS;
    localparam int IDXW = gdol_pkg::IDX_BITS;

    logic [PAD-1:0]  mask_pad;
    logic [PAD-1:0]  mask_reg;
    logic [CNTW-1:0] seg_cnt_next [NSEG];
    logic [CNTW-1:0] seg_cnt_reg  [NSEG];
    logic [CNTW-1:0] base_next    [NSEG];
    logic [CNTW-1:0] base_reg     [NSEG];
    logic [CNTW-1:0] prefix       [PAD];
    logic [CNTW-1:0] run;
    logic [CAP-1:0]  ge;
    logic [CAP-1:0]  first;
    logic [CNTW-1:0] pick;
    logic [CNTW-1:0] rank_reg;
    logic            tgt_found_reg;
    logic [IDXW-1:0] tgt_idx_reg;

    assign mask_pad = PAD'(mask);

    // per segment population count
    always_comb
    begin
        for (int s = 0; s < NSEG; s++)
        begin
            seg_cnt_next[s] = '0;
            for (int k = 0; k < SEG; k++)
            begin
                seg_cnt_next[s] = seg_cnt_next[s] + CNTW'(mask_pad[s*SEG+k]);
            end
        end
    end

    // exclusive segment bases
    always_comb
    begin
        base_next[0] = '0;
        for (int s = 1; s < NSEG; s++)
        begin
            base_next[s] = base_next[s-1] + seg_cnt_reg[s-1];
        end
    end

    // inclusive per cell prefix
    always_comb
    begin
        run = '0;
        for (int s = 0; s < NSEG; s++)
        begin
            run = base_reg[s];
            for (int k = 0; k < SEG; k++)
            begin
                run = run + CNTW'(mask_reg[s*SEG+k]);
                prefix[s*SEG+k] = run;
            end
        end
    end

    always_comb
    begin
        pick = '0;
        for (int j = 0; j < CAP; j++)
        begin
            ge[j] = CMPW'(prefix[j]) >= CMPW'(pos);
            if (hit[j])
            begin
                pick = pick | prefix[j];
            end
        end
        first[0] = ge[0];
        for (int j = 1; j < CAP; j++)
        begin
            first[j] = ge[j] && !ge[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cnt_en)
        begin
            mask_reg    <= mask_pad;
            seg_cnt_reg <= seg_cnt_next;
        end
        if (ctl.pfx_en)
        begin
            base_reg <= base_next;
        end
        if (ctl.sel_en)
        begin
            rank_reg      <= pick;
            tgt_found_reg <= |ge;
            tgt_idx_reg   <= gdol_pkg::onehot_to_idx(first);
        end
    end

    assign rank_val  = rank_reg;
    assign tgt_found = tgt_found_reg;
    assign tgt_idx   = tgt_idx_reg;

endmodule

`default_nettype wire

// ===== design/grouped_departure_order_list_unit.sv =====
// short path: ST_CMP then ST_UPD, for add, query miss, deactivate, remove, reactivate, edit miss, unused
// mode and query of an inactive or other-group item; query hit of an active item in its group and edit move
// add ST_CNT, ST_PFX and ST_SEL; one transaction at a time: in_stall holds until ST_UPD, held by out_stall, ends
// the long path is set by the segmented active prefix count over the cell row
// reset: asynchronous, empties the store at once (used and active marks clear), no result held
// top level: cell row, prefix count unit, sequencer and output register; uses gdol_pkg
`default_nettype none

module grouped_departure_order_list_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        mode,
    input  wire logic [15:0]       flight_id,
    input  wire logic [2:0]        group,
    input  wire logic signed [7:0] position,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic signed [7:0]      rank,
    output logic                   dropped
);

    `include "grouped_departure_order_list_unit_assert.svh"

    localparam int CAP  = gdol_pkg::CAPACITY;
    localparam int KEYW = gdol_pkg::KEY_BITS;
    localparam int GRPW = gdol_pkg::GROUP_BITS;
    localparam int POSW = gdol_pkg::POS_BITS;
    localparam int RNKW = gdol_pkg::RANK_BITS;
    localparam int IDXW = gdol_pkg::IDX_BITS;
    localparam int CNTW = gdol_pkg::CNT_BITS;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CMP  = 6'b000010,
        ST_CNT  = 6'b000100,
        ST_PFX  = 6'b001000,
        ST_SEL  = 6'b010000,
        ST_UPD  = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    gdol_pkg::mode_t       mode_reg;
    logic [KEYW-1:0]       key_reg;
    logic [GRPW-1:0]       grp_reg;
    logic [POSW-1:0]       pos_reg;
    logic [CAP-1:0]        hit_vec_reg;
    logic                  found_reg;
    logic [IDXW-1:0]       idx_reg;
    logic [GRPW-1:0]       sgrp_reg;
    logic                  sact_reg;
    logic [CNTW-1:0]       n_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [RNKW-1:0]       rank_out_reg, rank_out_next;
    logic                  dropped_reg, dropped_next;

    gdol_pkg::entry_t      cur      [CAP];
    gdol_pkg::entry_t      left_in  [CAP];
    gdol_pkg::entry_t      right_in [CAP];
    gdol_pkg::cell_ctl_t   ctl      [CAP];
    logic [CAP-1:0]        hit_vec;
    logic [CAP-1:0]        in_grp_vec;
    logic [CAP-1:0]        used_vec;
    logic [CAP-1:0]        active_vec;
    logic [CAP-1:0]        free_first;
    logic [CAP-1:0]        mask_vec;

    logic                  found_c;
    logic [GRPW-1:0]       sgrp_c;
    logic                  sact_c;
    logic [CNTW-1:0]       n_c;
    logic                  long_path;

    gdol_pkg::rank_ctl_t   rctl;
    logic [CNTW-1:0]       rank_val;
    logic                  tgt_found;
    logic [IDXW-1:0]       tgt_idx;

    logic                  advance;
    logic                  full;
    logic                  pos_neg;
    logic                  pos_zero;
    logic                  do_append;
    logic                  do_setact;
    logic                  set_val;
    logic                  do_remove;
    logic                  do_move;
    logic [CNTW-1:0]       idx_c;
    logic [CNTW-1:0]       tgt_c;
    logic [CNTW-1:0]       last_c;
    logic [CNTW-1:0]       dest_c;
    logic [GRPW-1:0]       load_grp;

    // cell row
    for (genvar j = 0; j < CAP; j++)
    begin : g_cell
        if (j == 0)
        begin : g_left_edge
            assign left_in[j] = '0;
        end
        else
        begin : g_left
            assign left_in[j] = cur[j-1];
        end
        if (j == CAP - 1)
        begin : g_right_edge
            assign right_in[j] = '0;
        end
        else
        begin : g_right
            assign right_in[j] = cur[j+1];
        end

        always_comb
        begin
            ctl[j].op      = gdol_pkg::OP_HOLD;
            ctl[j].act_val = set_val;
            if (advance)
            begin
                if (do_append && (CNTW'(j) == n_reg))
                begin
                    ctl[j].op = gdol_pkg::OP_LOAD;
                end
                else if (do_setact && (CNTW'(j) == idx_c))
                begin
                    ctl[j].op = gdol_pkg::OP_SET_ACT;
                end
                else if (do_remove)
                begin
                    if (CNTW'(j) == last_c)
                    begin
                        ctl[j].op = gdol_pkg::OP_CLEAR;
                    end
                    else if ((CNTW'(j) >= idx_c) && (CNTW'(j) < last_c))
                    begin
                        ctl[j].op = gdol_pkg::OP_FROM_RIGHT;
                    end
                end
                else if (do_move)
                begin
                    if (CNTW'(j) == dest_c)
                    begin
                        ctl[j].op = gdol_pkg::OP_LOAD;
                    end
                    else if ((dest_c < idx_c) && (CNTW'(j) > dest_c) && (CNTW'(j) <= idx_c))
                    begin
                        ctl[j].op = gdol_pkg::OP_FROM_LEFT;
                    end
                    else if ((dest_c >= idx_c) && (CNTW'(j) >= idx_c) && (CNTW'(j) < dest_c))
                    begin
                        ctl[j].op = gdol_pkg::OP_FROM_RIGHT;
                    end
                end
            end
        end

        gdol_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[j]),
            .left_in   (left_in[j]),
            .right_in  (right_in[j]),
            .load_key  (key_reg),
            .load_grp  (load_grp),
            .probe_key (key_reg),
            .probe_grp (sgrp_reg),
            .cur       (cur[j]),
            .hit       (hit_vec[j]),
            .in_grp    (in_grp_vec[j])
        );

        assign used_vec[j]   = cur[j].used;
        assign active_vec[j] = cur[j].active;
        if (j == 0)
        begin : g_free0
            assign free_first[j] = !cur[j].used;
        end
        else
        begin : g_free
            assign free_first[j] = !cur[j].used && cur[j-1].used;
        end
    end

    // key match results
    always_comb
    begin
        found_c = |hit_vec;
        sgrp_c  = '0;
        sact_c  = 1'b0;
        for (int j = 0; j < CAP; j++)
        begin
            if (hit_vec[j])
            begin
                sgrp_c = sgrp_c | cur[j].grp;
                sact_c = sact_c | cur[j].active;
            end
        end
        if (used_vec[CAP-1])
        begin
            n_c = CNTW'(CAP);
        end
        else
        begin
            n_c = CNTW'(gdol_pkg::onehot_to_idx(free_first));
        end
    end

    assign mask_vec = in_grp_vec & ~((mode_reg == gdol_pkg::MODE_EDIT) ? hit_vec_reg : '0);

    assign rctl.cnt_en = (state_reg == ST_CNT);
    assign rctl.pfx_en = (state_reg == ST_PFX);
    assign rctl.sel_en = (state_reg == ST_SEL);

    gdol_rank u_rank (
        .clk       (clk),
        .ctl       (rctl),
        .mask      (mask_vec),
        .hit       (hit_vec_reg),
        .pos       (pos_reg),
        .rank_val  (rank_val),
        .tgt_found (tgt_found),
        .tgt_idx   (tgt_idx)
    );

    // update decode
    assign full     = (n_reg == CNTW'(CAP));
    assign pos_neg  = pos_reg[POSW-1];
    assign pos_zero = (pos_reg == '0);
    assign idx_c    = CNTW'(idx_reg);
    assign tgt_c    = CNTW'(tgt_idx);
    assign last_c   = n_reg - CNTW'(1);
    assign dest_c   = !tgt_found ? last_c : ((tgt_c > idx_c) ? (tgt_c - CNTW'(1)) : tgt_c);

    assign do_append = (mode_reg == gdol_pkg::MODE_ADD) && !found_reg && !full;
    assign do_setact = found_reg && (((mode_reg == gdol_pkg::MODE_ADD) && !sact_reg)
                     || ((mode_reg == gdol_pkg::MODE_EDIT) && (!sact_reg || pos_neg)));
    assign set_val   = !sact_reg && (sgrp_reg == grp_reg);
    assign do_remove = (mode_reg == gdol_pkg::MODE_EDIT) && found_reg && sact_reg && pos_zero;
    assign do_move   = (mode_reg == gdol_pkg::MODE_EDIT) && found_reg && sact_reg
                     && !pos_neg && !pos_zero;
    assign load_grp  = do_append ? grp_reg : sgrp_reg;

    assign long_path = found_c && (((mode_reg == gdol_pkg::MODE_QUERY) && sact_c
                     && (sgrp_c == grp_reg))
                     || ((mode_reg == gdol_pkg::MODE_EDIT) && sact_c && !pos_reg[POSW-1]
                     && (pos_reg != '0)));

    assign advance = (state_reg == ST_UPD) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = long_path ? ST_CNT : ST_UPD;
            end
            ST_CNT:
            begin
                state_next = ST_PFX;
            end
            ST_PFX:
            begin
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        rank_out_next  = rank_out_reg;
        dropped_next   = dropped_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            rank_out_next  = '0;
            dropped_next   = (mode_reg == gdol_pkg::MODE_ADD) && !found_reg && full;
            if ((mode_reg == gdol_pkg::MODE_QUERY) && found_reg)
            begin
                if (!sact_reg || (sgrp_reg != grp_reg))
                begin
                    rank_out_next = '1;
                end
                else
                begin
                    rank_out_next = RNKW'(rank_val);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_out_reg <= rank_out_next;
        dropped_reg  <= dropped_next;
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            mode_reg <= gdol_pkg::mode_t'(mode);
            key_reg  <= flight_id[KEYW-1:0];
            grp_reg  <= group;
            pos_reg  <= position;
        end
        if (state_reg == ST_CMP)
        begin
            hit_vec_reg <= hit_vec;
            found_reg   <= found_c;
            idx_reg     <= gdol_pkg::onehot_to_idx(hit_vec);
            sgrp_reg    <= sgrp_c;
            sact_reg    <= sact_c;
            n_reg       <= n_c;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign rank      = rank_out_reg;
    assign dropped   = dropped_reg;

    `GDOL_ASSERT_ALWAYS(a_key_unique, $onehot0(hit_vec))
    `GDOL_ASSERT_ALWAYS(a_used_prefix, ((used_vec >> 1) & ~used_vec) == '0)
    `GDOL_ASSERT_NEXT(a_append_grows, advance && do_append, $countones(used_vec) == $past($countones(used_vec)) + 1)
    `GDOL_ASSERT_NEXT(a_query_keeps, advance && (mode_reg == gdol_pkg::MODE_QUERY), $stable(used_vec) && $stable(active_vec))

endmodule

`default_nettype wire

// ===== sim/grouped_departure_order_list_unit_tb.sv =====
// testbench for grouped_departure_order_list_unit: directed and random transactions,
// results checked against a predictor of the ordered per-group store
// depends on gdol_pkg and the unit under test
`timescale 1ns / 100ps

module grouped_departure_order_list_unit_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int POOL_SIZE   = 96;
    localparam int NUM_RANDOM  = 450;

    class order_list_model;
        typedef struct packed {
            logic signed [7:0] rank;
            logic              dropped;
        } result_t;

        logic [15:0] cell_key[gdol_pkg::CAPACITY];
        logic [2:0]  cell_grp[gdol_pkg::CAPACITY];
        bit          cell_act[gdol_pkg::CAPACITY];
        bit          cell_used[gdol_pkg::CAPACITY];
        result_t     expected_results[$];
        int          errors;

        function new();
            for (int i = 0; i < gdol_pkg::CAPACITY; i++)
            begin
                cell_key[i]  = '0;
                cell_grp[i]  = '0;
                cell_act[i]  = 1'b0;
                cell_used[i] = 1'b0;
            end
            errors = 0;
        endfunction

        // open a cell at slot and shift the tail of the row up by one
        function void put_in(int slot, int n, logic [15:0] id, logic [2:0] g);
            if (n >= gdol_pkg::CAPACITY || slot < 0 || slot > n)
                return;
            for (int j = n; j > slot; j--)
            begin
                cell_key[j] = cell_key[j-1];
                cell_grp[j] = cell_grp[j-1];
                cell_act[j] = cell_act[j-1];
            end
            cell_key[slot] = id;
            cell_grp[slot] = g;
            cell_act[slot] = 1'b1;
            cell_used[n]   = 1'b1;
        endfunction

        function void apply_transaction(gdol_pkg::mode_t m, logic [15:0] id, logic [2:0] g,
                                        logic signed [7:0] pos);
            int          n;
            int          idx;
            int          r;
            int          p;
            int          cnt;
            int          slot;
            logic [2:0]  sg;
            result_t     res;
            n   = 0;
            idx = -1;
            r   = 0;
            p   = int'(pos);
            res = '0;
            while (n < gdol_pkg::CAPACITY && cell_used[n])
                n++;
            for (int i = 0; i < n; i++)
            begin
                if (cell_key[i] == id)
                begin
                    idx = i;
                    break;
                end
            end
            case (m)
                gdol_pkg::MODE_ADD:
                begin
                    if (idx >= 0)
                    begin
                        if (!cell_act[idx])
                            cell_act[idx] = (cell_grp[idx] == g);
                    end
                    else if (n >= gdol_pkg::CAPACITY)
                        res.dropped = 1'b1;
                    else
                        put_in(n, n, id, g);
                end
                gdol_pkg::MODE_QUERY:
                begin
                    if (idx >= 0)
                    begin
                        if (cell_grp[idx] != g || !cell_act[idx])
                            r = -1;
                        else
                            for (int j = 0; j <= idx; j++)
                                if (cell_grp[j] == cell_grp[idx] && cell_act[j])
                                    r++;
                    end
                end
                gdol_pkg::MODE_EDIT:
                begin
                    if (idx >= 0)
                    begin
                        if (!cell_act[idx])
                            cell_act[idx] = (cell_grp[idx] == g);
                        else if (p < 0)
                            cell_act[idx] = 1'b0;
                        else
                        begin
                            sg = cell_grp[idx];
                            for (int j = idx; j + 1 < n; j++)
                            begin
                                cell_key[j] = cell_key[j+1];
                                cell_grp[j] = cell_grp[j+1];
                                cell_act[j] = cell_act[j+1];
                            end
                            cell_used[n-1] = 1'b0;
                            cell_act[n-1]  = 1'b0;
                            n--;
                            if (p != 0)
                            begin
                                cnt  = p;
                                slot = n;
                                for (int j = 0; j < n; j++)
                                begin
                                    if (cell_grp[j] == sg)
                                    begin
                                        cnt -= cell_act[j];
                                        if (cnt < 1)
                                        begin
                                            slot = j;
                                            break;
                                        end
                                    end
                                end
                                put_in(slot, n, id, sg);
                            end
                        end
                    end
                end
                default: ;
            endcase
            res.rank = 8'(r);
            expected_results = {expected_results, res};
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic signed [7:0] rank_seen, logic dropped_seen);
            result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result rank %0d dropped %0b",
                                          rank_seen, dropped_seen));
                return;
            end
            want = expected_results.pop_front();
            if (rank_seen !== want.rank)
                report_mismatch($sformatf("rank %0d, want %0d", rank_seen, want.rank));
            if (dropped_seen !== want.dropped)
                report_mismatch($sformatf("dropped %0b, want %0b", dropped_seen, want.dropped));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        mode;
    logic [15:0]       flight_id;
    logic [2:0]        group;
    logic signed [7:0] position;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic signed [7:0] rank;
    logic              dropped;

    order_list_model   model;
    bit                quiet;
    int                idle_cycles;
    logic [15:0]       key_pool[POOL_SIZE];
    logic [2:0]        pool_grp[POOL_SIZE];

    grouped_departure_order_list_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .flight_id (flight_id),
        .group     (group),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rank      (rank),
        .dropped   (dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 15);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            model.check_result(rank, dropped);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input gdol_pkg::mode_t m, input logic [15:0] id,
                             input logic [2:0] g, input logic signed [7:0] pos);
        while (!quiet && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        flight_id <= id;
        group     <= g;
        position  <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model.apply_transaction(m, id, g, pos);
        @(negedge clk);
    endtask

    initial
    begin
        int                k;
        int                pick;
        int                add_pct;
        int                pool_used;
        gdol_pkg::mode_t   m;
        logic [15:0]       id;
        logic [2:0]        g;
        logic signed [7:0] pos;

        model       = new();
        quiet       = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = gdol_pkg::MODE_NONE;
        flight_id   = '0;
        group       = '0;
        position    = '0;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        pool_grp[0] = 3'd0;
        pool_grp[1] = 3'd7;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            key_pool[i] = 16'($urandom_range(0, 65535));
            pool_grp[i] = 3'($urandom_range(0, 7));
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty store, unknown items, unused mode, then first adds in two groups
        send_item(gdol_pkg::MODE_QUERY, key_pool[0], 3'd0, 8'sd0);
        send_item(gdol_pkg::MODE_EDIT, key_pool[0], 3'd0, 8'sd5);
        send_item(gdol_pkg::MODE_NONE, key_pool[1], 3'd7, -8'sd1);
        send_item(gdol_pkg::MODE_ADD, key_pool[0], 3'd0, 8'sd0);
        send_item(gdol_pkg::MODE_ADD, key_pool[1], 3'd7, 8'sd0);
        send_item(gdol_pkg::MODE_ADD, key_pool[2], 3'd0, 8'sd0);
        send_item(gdol_pkg::MODE_ADD, key_pool[3], 3'd0, 8'sd0);
        send_item(gdol_pkg::MODE_ADD, key_pool[4], 3'd7, 8'sd0);
        // add of an active item
        send_item(gdol_pkg::MODE_ADD, key_pool[0], 3'd0, 8'sd0);
        send_item(gdol_pkg::MODE_QUERY, key_pool[2], 3'd0, 8'sd0);
        send_item(gdol_pkg::MODE_QUERY, key_pool[2], 3'd7, 8'sd0);
        // move to front, then past the end
        send_item(gdol_pkg::MODE_EDIT, key_pool[3], 3'd0, 8'sd1);
        send_item(gdol_pkg::MODE_QUERY, key_pool[3], 3'd0, 8'sd0);
        send_item(gdol_pkg::MODE_EDIT, key_pool[2], 3'd0, 8'sd64);
        send_item(gdol_pkg::MODE_QUERY, key_pool[2], 3'd0, 8'sd0);
        // deactivate, reactivate attempts with changed and matching group
        send_item(gdol_pkg::MODE_EDIT, key_pool[0], 3'd0, -8'sd1);
        send_item(gdol_pkg::MODE_QUERY, key_pool[0], 3'd0, 8'sd0);
        send_item(gdol_pkg::MODE_ADD, key_pool[0], 3'd3, 8'sd0);
        send_item(gdol_pkg::MODE_EDIT, key_pool[0], 3'd3, 8'sd2);
        send_item(gdol_pkg::MODE_EDIT, key_pool[0], 3'd0, 8'sd9);
        send_item(gdol_pkg::MODE_QUERY, key_pool[0], 3'd0, 8'sd0);
        // position below minus one, then remove
        send_item(gdol_pkg::MODE_EDIT, key_pool[4], 3'd7, 8'sh80);
        send_item(gdol_pkg::MODE_EDIT, key_pool[1], 3'd7, 8'sd0);
        send_item(gdol_pkg::MODE_QUERY, key_pool[1], 3'd7, 8'sd0);
        send_item(gdol_pkg::MODE_NONE, key_pool[2], 3'd0, 8'sd127);

        // small pool first, then a wide pool that fills the store, then mixed
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            quiet     = (i >= 200 && i < 300);
            pool_used = (i < 150) ? 20 : POOL_SIZE;
            add_pct   = (i >= 150 && i < 300) ? 60 : 30;
            k         = $urandom_range(0, pool_used - 1);
            id        = ($urandom_range(0, 99) < 5) ? 16'($urandom_range(0, 65535)) : key_pool[k];
            g         = ($urandom_range(0, 99) < 85) ? pool_grp[k] : 3'($urandom_range(0, 7));
            pick      = $urandom_range(0, 99);
            if (pick < add_pct)
                m = gdol_pkg::MODE_ADD;
            else if (pick < add_pct + (100 - add_pct) / 2)
                m = gdol_pkg::MODE_QUERY;
            else if (pick < 95)
                m = gdol_pkg::MODE_EDIT;
            else
                m = gdol_pkg::MODE_NONE;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                pos = -8'sd1;
            else if (pick < 20 && add_pct == 30)
                pos = 8'sd0;
            else if (pick < 25)
                pos = 8'($urandom_range(0, 255));
            else if (pick < 30)
                pos = 8'sd64;
            else
                pos = 8'($urandom_range(1, 12));
            send_item(m, id, g, pos);
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (model.expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (model.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== grouped_departure_order_list_unit.f =====
+incdir+design
design/gdol_pkg.sv
design/gdol_cell.sv
design/gdol_rank.sv
design/grouped_departure_order_list_unit.sv
sim/grouped_departure_order_list_unit_tb.sv
